FILE: hdl/cpg_pkg.sv
// Package for the circle point generator: widths, item codes and the
// record handed from the front end to the point emitter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpg_pkg;

  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 11;

  // Offset a is unsigned, offset b signed (it can reach -1), decision signed.
  localparam int A_W    = RADIUS_BITS + 1;
  localparam int B_W    = RADIUS_BITS + 2;
  localparam int D_W    = RADIUS_BITS + 3;
  localparam int CALC_W = RADIUS_BITS + 5;
  localparam int PT_W   = COORD_BITS + 2;
  localparam int WIDE_W = ((PT_W > B_W) ? PT_W : B_W) + 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_POINTS  = 8;
  localparam int K_W         = $clog2(NUM_POINTS);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // One step's worth of work: the centre, the offset pair to mirror and
  // whether this step finishes the circle.
  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [A_W-1:0]        a;
    logic signed [B_W-1:0] b;
    logic                  fin;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage : cpg_pkg

`default_nettype wire

FILE: hdl/cpg_in_if.sv
// Input channel of the circle point generator: valid/ready plus the item
// fields. Depends on cpg_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cpg_in_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [cpg_pkg::COORD_BITS-1:0]   center_x;
  logic [cpg_pkg::COORD_BITS-1:0]   center_y;
  logic [cpg_pkg::RADIUS_BITS-1:0]  radius;

  modport source (output valid, op, center_x, center_y, radius, input ready);
  modport sink   (input valid, op, center_x, center_y, radius, output ready);
endinterface : cpg_in_if

`default_nettype wire

FILE: hdl/cpg_out_if.sv
// Result channel of the circle point generator: valid/ready plus one
// outline point per transaction. Depends on cpg_pkg for the widths.
`timescale 1ns / 1ps
`default_nettype none

interface cpg_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cpg_pkg::PT_W-1:0]   point_x;
  logic signed [cpg_pkg::PT_W-1:0]   point_y;
  logic                              last;
  logic                              done_res;

  modport source (output valid, point_x, point_y, last, done_res, input ready);
  modport sink   (input valid, point_x, point_y, last, done_res, output ready);
endinterface : cpg_out_if

`default_nettype wire

FILE: hdl/cpg_front.sv
// Front end: accepts input transactions, holds the circle state and runs
// the midpoint decision update, queuing one job per step. Uses cpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpg_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  cpg_in_if.sink                  in_chan,
  input  wire cpg_pkg::q_status_t q_stat,
  output logic                    push,
  output cpg_pkg::job_t           push_job
);

  localparam int CW = cpg_pkg::CALC_W;

  logic [cpg_pkg::COORD_BITS-1:0]  center_col_r, center_col_nxt;
  logic [cpg_pkg::COORD_BITS-1:0]  center_row_r, center_row_nxt;
  logic [cpg_pkg::RADIUS_BITS-1:0] radius_r, radius_nxt;
  logic [cpg_pkg::A_W-1:0]         a_r, a_nxt;
  logic signed [cpg_pkg::B_W-1:0]  b_r, b_nxt;
  logic signed [cpg_pkg::D_W-1:0]  d_r, d_nxt;
  logic                            active_r, active_nxt;

  logic                  accept;
  logic signed [CW-1:0]  d_w, a_w, b_w, r_w;
  logic signed [CW-1:0]  d_upd, a_upd, b_upd;
  logic                  take_a, take_b, fin;

  assign in_chan.ready = !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    d_w = {{(CW - cpg_pkg::D_W){d_r[cpg_pkg::D_W-1]}}, d_r};
    a_w = {{(CW - cpg_pkg::A_W){1'b0}}, a_r};
    b_w = {{(CW - cpg_pkg::B_W){b_r[cpg_pkg::B_W-1]}}, b_r};
    r_w = {{(CW - cpg_pkg::RADIUS_BITS){1'b0}}, radius_r};

    take_a = d_w >= (a_w + a_w);
    take_b = d_w < ((r_w - b_w) + (r_w - b_w));

    priority if (take_a) begin
      d_upd = d_w - (a_w + a_w) - CW'(1);
      a_upd = a_w + CW'(1);
      b_upd = b_w;
    end else if (take_b) begin
      d_upd = d_w + (b_w + b_w) - CW'(1);
      a_upd = a_w;
      b_upd = b_w - CW'(1);
    end else begin
      d_upd = d_w + ((b_w - a_w - CW'(1)) + (b_w - a_w - CW'(1)));
      a_upd = a_w + CW'(1);
      b_upd = b_w - CW'(1);
    end
    fin = b_upd < a_upd;
  end

  always_comb begin
    center_col_nxt = center_col_r;
    center_row_nxt = center_row_r;
    radius_nxt     = radius_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    d_nxt          = d_r;
    active_nxt     = active_r;
    push           = 1'b0;

    push_job.cx  = center_col_r;
    push_job.cy  = center_row_r;
    push_job.a   = a_r;
    push_job.b   = b_r;
    push_job.fin = fin;

    if (accept) begin
      if (in_chan.op == cpg_pkg::OP_START) begin
        center_col_nxt = in_chan.center_x;
        center_row_nxt = in_chan.center_y;
        radius_nxt     = in_chan.radius;
        a_nxt          = '0;
        b_nxt          = {{(cpg_pkg::B_W - cpg_pkg::RADIUS_BITS){1'b0}}, in_chan.radius};
        d_nxt          = {{(cpg_pkg::D_W - cpg_pkg::RADIUS_BITS){1'b0}}, in_chan.radius}
                         - cpg_pkg::D_W'(1);
        active_nxt     = 1'b1;
      end else if (active_r) begin
        push       = 1'b1;
        a_nxt      = a_upd[cpg_pkg::A_W-1:0];
        b_nxt      = b_upd[cpg_pkg::B_W-1:0];
        d_nxt      = d_upd[cpg_pkg::D_W-1:0];
        active_nxt = !fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_col_r <= '0;
      center_row_r <= '0;
      radius_r     <= '0;
      a_r          <= '0;
      b_r          <= '0;
      d_r          <= '0;
      active_r     <= 1'b0;
    end else begin
      center_col_r <= center_col_nxt;
      center_row_r <= center_row_nxt;
      radius_r     <= radius_nxt;
      a_r          <= a_nxt;
      b_r          <= b_nxt;
      d_r          <= d_nxt;
      active_r     <= active_nxt;
    end
  end

endmodule : cpg_front

`default_nettype wire

FILE: hdl/cpg_queue.sv
// Short job queue between the front end and the point emitter.
// Register based, first in first out. Uses cpg_pkg for the job record.
`timescale 1ns / 1ps
`default_nettype none

module cpg_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire cpg_pkg::job_t push_job,
  input  wire logic          pop,
  output cpg_pkg::job_t      head_job,
  output cpg_pkg::q_status_t q_stat
);

  cpg_pkg::job_t                 slot_r [cpg_pkg::QUEUE_DEPTH];
  logic [cpg_pkg::PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [cpg_pkg::PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [cpg_pkg::CNT_W-1:0]     count_r, count_nxt;

  assign head_job     = slot_r[rd_ptr_r];
  assign q_stat.full  = count_r == cpg_pkg::CNT_W'(cpg_pkg::QUEUE_DEPTH);
  assign q_stat.empty = count_r == '0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == cpg_pkg::PTR_W'(cpg_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + cpg_pkg::PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == cpg_pkg::PTR_W'(cpg_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + cpg_pkg::PTR_W'(1);
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + cpg_pkg::CNT_W'(1);
      2'b01:   count_nxt = count_r - cpg_pkg::CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_stat.full || pop))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("job queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cpg_pkg::CNT_W'(cpg_pkg::QUEUE_DEPTH))
    else $error("job queue count out of range");

endmodule : cpg_queue

`default_nettype wire

FILE: hdl/cpg_back.sv
// Point emitter: mirrors the job at the head of the queue into eight
// points, one per cycle while out_chan is ready, via an output register. Uses cpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpg_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cpg_pkg::job_t      head_job,
  input  wire cpg_pkg::q_status_t q_stat,
  output logic                    pop,
  cpg_out_if.source               out_chan
);

  localparam int WW = cpg_pkg::WIDE_W;

  logic [cpg_pkg::K_W-1:0]          k_r, k_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic signed [cpg_pkg::PT_W-1:0]  point_x_r, point_y_r;
  logic                             last_r, done_r;

  logic                  emit, final_pt;
  logic signed [WW-1:0]  cx_w, cy_w, a_w, b_w, off_x, off_y, px_w, py_w;

  assign emit     = !q_stat.empty && (!out_valid_r || out_chan.ready);
  assign final_pt = k_r == cpg_pkg::K_W'(cpg_pkg::NUM_POINTS - 1);
  assign pop      = emit && final_pt;

  // Bit 0 of the point index swaps the offsets, bit 1 negates the column
  // offset and bit 2 the row offset.
  always_comb begin
    cx_w  = {{(WW - cpg_pkg::COORD_BITS){1'b0}}, head_job.cx};
    cy_w  = {{(WW - cpg_pkg::COORD_BITS){1'b0}}, head_job.cy};
    a_w   = {{(WW - cpg_pkg::A_W){1'b0}}, head_job.a};
    b_w   = {{(WW - cpg_pkg::B_W){head_job.b[cpg_pkg::B_W-1]}}, head_job.b};
    off_x = k_r[0] ? b_w : a_w;
    off_y = k_r[0] ? a_w : b_w;
    px_w  = k_r[1] ? (cx_w - off_x) : (cx_w + off_x);
    py_w  = k_r[2] ? (cy_w - off_y) : (cy_w + off_y);
  end

  always_comb begin
    k_nxt         = emit ? k_r + cpg_pkg::K_W'(1) : k_r;
    out_valid_nxt = emit ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      point_x_r <= px_w[cpg_pkg::PT_W-1:0];
      point_y_r <= py_w[cpg_pkg::PT_W-1:0];
      last_r    <= final_pt;
      done_r    <= final_pt && head_job.fin;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.point_x  = point_x_r;
  assign out_chan.point_y  = point_y_r;
  assign out_chan.last     = last_r;
  assign out_chan.done_res = done_r;

  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> last_r)
    else $error("done flag raised on a point that is not the last of its step");

  a_last_wraps_index: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (k_r == '0))
    else $error("point index did not wrap after the eighth point");

endmodule : cpg_back

`default_nettype wire

FILE: hdl/circle_point_generator_unit.sv
// Circle point generator, top level. Instantiates cpg_front, cpg_queue and
// cpg_back; uses cpg_pkg, cpg_in_if and cpg_out_if.
//
// Usage: the input channel takes one transaction per item. A start item
// (op = 0) loads centre and radius and produces nothing; a step item
// (op = 1) produces eight outline points on the result channel, the eighth
// with last set, and with done_res also set when that step ends the circle.
// A step while no circle is active is accepted and produces nothing.
//
// A step's job passes through the job queue and then the output register
// before its first point appears. Points leave at one per cycle while the
// result channel is ready. The front end takes a new item every cycle
// while the two-entry job queue has room, so starts and steps overlap the
// emission of earlier steps.
//
// Reset (rst_n low at a clock edge) clears the circle state, empties the
// queue and drops any pending result. When the receiver stalls, the current
// point holds in the output register, emission pauses, and once the queue
// fills the input channel deasserts ready.
`timescale 1ns / 1ps
`default_nettype none

module circle_point_generator_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  cpg_in_if.sink    in_chan,
  cpg_out_if.source out_chan
);

  logic               push;
  logic               pop;
  cpg_pkg::job_t      push_job;
  cpg_pkg::job_t      head_job;
  cpg_pkg::q_status_t q_stat;

  cpg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  cpg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  cpg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule : circle_point_generator_unit

`default_nettype wire
